// ===== hdl/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// maf_pkg
// shared types, codes and sizes for the mac address filter match block
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

    localparam int MAX_FILTERS = 8;
    localparam int CNT_W       = $clog2(MAX_FILTERS + 1);
    localparam int MAC_W       = 48;
    localparam int MASK_W      = 8;
    localparam int USED_W      = 4;
    localparam int KIND_W      = 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam int EN_DST = 0;
    localparam int EN_SRC = 1;
    localparam int EN_AP  = 2;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_FRAME = 2'd2,
        REQ_SPARE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DROPPED = 2'd2,
        ST_SPARE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_CLEAR,
        OP_MATCH,
        OP_DROP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  dst;
        logic [MAC_W-1:0]  src;
        logic [MAC_W-1:0]  ap;
        logic [2:0]        en;
    } cmd_t;

    function automatic logic [USED_W-1:0] sat_used(input logic [CNT_W-1:0] count);
        logic [31:0] c;
        c = 32'(count);
        return (c > 32'd15) ? USED_W'(15) : c[USED_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/maf_front.sv =====
// ----------------------------------------------------------------------------
// maf_front
// accepts request transfers and classifies them into back-end commands
// ----------------------------------------------------------------------------
`default_nettype none

module maf_front
    import maf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       req_type,
    input  wire logic             rx_error,
    input  wire logic [KIND_W-1:0] frame_kind,
    input  wire logic [MAC_W-1:0] dst_mac,
    input  wire logic [MAC_W-1:0] src_mac,
    input  wire logic [MAC_W-1:0] ap_mac,
    input  wire logic [2:0]       enables,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output cmd_t                  cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign in_ready = !valid_reg || cmd_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        cmd_next      = '0;
        cmd_next.dst  = dst_mac;
        cmd_next.src  = src_mac;
        cmd_next.ap   = ap_mac;
        cmd_next.en   = enables;
        cmd_next.kind = frame_kind;
        unique case (req_t'(req_type))
            REQ_ADD:   cmd_next.op = OP_ADD;
            REQ_CLEAR: cmd_next.op = OP_CLEAR;
            REQ_FRAME: cmd_next.op = rx_error ? OP_DROP : OP_MATCH;
            default:   cmd_next.op = OP_NOP;
        endcase
        valid_next = take || (valid_reg && !cmd_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// ===== hdl/maf_queue.sv =====
// ----------------------------------------------------------------------------
// maf_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module maf_queue
    import maf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/maf_back.sv =====
// ----------------------------------------------------------------------------
// maf_back
// filter table, parallel address compare and registered result
// ----------------------------------------------------------------------------
`default_nettype none

module maf_back
    import maf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  wire logic         res_ready,
    output logic [1:0]        status,
    output logic [MASK_W-1:0] match_mask,
    output logic [KIND_W-1:0] kind_out,
    output logic [USED_W-1:0] entries_used
);

    localparam int HIT_W = (MAX_FILTERS > MASK_W) ? MAX_FILTERS : MASK_W;

    logic [MAC_W-1:0]  dst_reg [MAX_FILTERS];
    logic [MAC_W-1:0]  src_reg [MAX_FILTERS];
    logic [MAC_W-1:0]  ap_reg  [MAX_FILTERS];
    logic [2:0]        en_reg  [MAX_FILTERS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;
    logic [USED_W-1:0] used_reg;

    logic              pop;
    logic              full;
    logic              write_en;
    logic [HIT_W-1:0]  hit;

    assign cmd_ready = !out_valid_reg || res_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign full      = (32'(count_reg) >= 32'(MAX_FILTERS));
    assign write_en  = pop && (cmd.op == OP_ADD) && !full;

    always_comb
    begin
        hit = '0;
        for (int i = 0; i < MAX_FILTERS; i++)
        begin
            hit[i] = (32'(i) < 32'(count_reg))
                && (!en_reg[i][EN_DST] || (dst_reg[i] == cmd.dst))
                && (!en_reg[i][EN_SRC] || (src_reg[i] == cmd.src))
                && (!en_reg[i][EN_AP]  || (ap_reg[i]  == cmd.ap));
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        mask_next   = '0;
        kind_next   = '0;
        unique case (cmd.op)
            OP_ADD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            OP_MATCH:
            begin
                mask_next = hit[MASK_W-1:0];
                kind_next = cmd.kind;
            end
            OP_DROP:
            begin
                status_next = ST_DROPPED;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (!pop)
        begin
            count_next = count_reg;
        end
        out_valid_next = pop || (out_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_FILTERS; i++)
        begin
            if (write_en && (32'(count_reg) == 32'(i)))
            begin
                dst_reg[i] <= cmd.dst;
                src_reg[i] <= cmd.src;
                ap_reg[i]  <= cmd.ap;
                en_reg[i]  <= cmd.en;
            end
        end
        if (pop)
        begin
            status_reg <= status_next;
            mask_reg   <= mask_next;
            kind_reg   <= kind_next;
            used_reg   <= sat_used(count_next);
        end
    end

    assign res_valid    = out_valid_reg;
    assign status       = status_reg;
    assign match_mask   = mask_reg;
    assign kind_out     = kind_reg;
    assign entries_used = used_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_FILTERS))
        else $error("filter count beyond table size");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (cmd.op == OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty table");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("add did not grow table by one");

    a_quiet_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status_reg != ST_OK)) |-> ((mask_reg == '0) && (kind_reg == '0)))
        else $error("mask or kind set on a non-ok result");

endmodule

`default_nettype wire

// ===== hdl/mac_address_filter_match.sv =====
// ----------------------------------------------------------------------------
// mac_address_filter_match
// wireless frame filter table with parallel address matching
// ----------------------------------------------------------------------------
// Takes one request transfer per cycle while s_axis_tready is high and returns
// one result transfer per request, in order. Each request passes through three
// registers: the front-end command register, one slot of the two-entry command
// queue and the back-end result register. The back end compares a frame's three
// addresses against every table entry in parallel. The queue between the front
// and back ends lets the input keep streaming while the output is held off. The
// table comes out of reset empty and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_address_filter_match
    import maf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // dst_mac[47:0], src_mac[95:48], ap_mac[143:96], dst_enable[144],
    // src_enable[145], ap_enable[146], zero fill [151:147]
    input  wire logic [151:0] s_axis_tdata,
    // req_type[1:0], rx_error[2], frame_kind[4:3]
    input  wire logic [4:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // match_mask[7:0], entries_used[11:8], zero fill [15:12]
    output logic [15:0]       m_axis_tdata,
    // status[1:0], kind_out[3:2]
    output logic [3:0]        m_axis_tuser
);

    logic              fq_valid;
    logic              fq_ready;
    cmd_t              fq_cmd;
    logic              qb_valid;
    logic              qb_ready;
    cmd_t              qb_cmd;
    logic [1:0]        status;
    logic [MASK_W-1:0] match_mask;
    logic [KIND_W-1:0] kind_out;
    logic [USED_W-1:0] entries_used;

    maf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req_type   (s_axis_tuser[1:0]),
        .rx_error   (s_axis_tuser[2]),
        .frame_kind (s_axis_tuser[4:3]),
        .dst_mac    (s_axis_tdata[47:0]),
        .src_mac    (s_axis_tdata[95:48]),
        .ap_mac     (s_axis_tdata[143:96]),
        .enables    (s_axis_tdata[146:144]),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    maf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    maf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (qb_valid),
        .cmd_ready    (qb_ready),
        .cmd          (qb_cmd),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .status       (status),
        .match_mask   (match_mask),
        .kind_out     (kind_out),
        .entries_used (entries_used)
    );

    assign m_axis_tdata = {4'b0000, entries_used, match_mask};
    assign m_axis_tuser = {kind_out, status};

endmodule

`default_nettype wire

// ===== tb/mac_address_filter_match_test.sv =====
// ----------------------------------------------------------------------------
// mac_address_filter_match_test
// self-checking testbench for the mac address filter match block
// ----------------------------------------------------------------------------
// Drives add, clear, frame and unused requests over the input stream. A
// scoreboard keeps its own copy of the filter table, works out the result of
// every accepted request and checks each output transfer against the oldest
// pending result. A short directed part covers the corners. A random part
// then fills and clears the table and sends frames built from stored filters,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_address_filter_match_test;

    import maf_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int ITEM_TARGET    = 1675;
    localparam int LONG_HOLD      = 400;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct {
        req_t               req;
        logic               rx_error;
        logic [KIND_W-1:0]  kind;
        logic [MAC_W-1:0]   dst;
        logic [MAC_W-1:0]   src;
        logic [MAC_W-1:0]   ap;
        logic [2:0]         en;
    } filter_request_t;

    typedef struct {
        status_t            status;
        logic [MASK_W-1:0]  mask;
        logic [KIND_W-1:0]  kind;
        logic [USED_W-1:0]  used;
    } filter_verdict_t;

    class filter_checker;
        int                 filter_count;
        logic [MAC_W-1:0]   dst_tab[MAX_FILTERS];
        logic [MAC_W-1:0]   src_tab[MAX_FILTERS];
        logic [MAC_W-1:0]   ap_tab[MAX_FILTERS];
        logic [2:0]         en_tab[MAX_FILTERS];
        filter_verdict_t    verdicts[$];
        int                 failures;

        function new();
            filter_count = 0;
            failures     = 0;
        endfunction

        function void note_request(filter_request_t r);
            filter_verdict_t v;
            v.status = ST_OK;
            v.mask   = '0;
            v.kind   = '0;
            case (r.req)
                REQ_ADD:
                begin
                    if (filter_count >= MAX_FILTERS)
                    begin
                        v.status = ST_FULL;
                    end
                    else
                    begin
                        dst_tab[filter_count] = r.dst;
                        src_tab[filter_count] = r.src;
                        ap_tab[filter_count]  = r.ap;
                        en_tab[filter_count]  = r.en;
                        filter_count++;
                    end
                end
                REQ_CLEAR:
                begin
                    filter_count = 0;
                end
                REQ_FRAME:
                begin
                    if (r.rx_error)
                    begin
                        v.status = ST_DROPPED;
                    end
                    else
                    begin
                        v.kind = r.kind;
                        for (int i = 0; i < filter_count; i++)
                        begin
                            if ((!en_tab[i][EN_DST] || dst_tab[i] == r.dst) &&
                                (!en_tab[i][EN_SRC] || src_tab[i] == r.src) &&
                                (!en_tab[i][EN_AP]  || ap_tab[i] == r.ap) &&
                                i < MASK_W)
                            begin
                                v.mask[i] = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            v.used = (filter_count > 15) ? USED_W'(15) : USED_W'(filter_count);
            verdicts.push_back(v);
        endfunction

        function void check_result(logic [15:0] data, logic [3:0] user);
            filter_verdict_t v;
            if (verdicts.size() == 0)
            begin
                $error("result transfer with nothing pending: tdata %h tuser %h", data, user);
                failures++;
                return;
            end
            v = verdicts.pop_front();
            if (user[1:0] !== v.status)
            begin
                $error("status: expected %0d, actual %0d", v.status, user[1:0]);
                failures++;
            end
            if (data[7:0] !== v.mask)
            begin
                $error("match_mask: expected %h, actual %h", v.mask, data[7:0]);
                failures++;
            end
            if (user[3:2] !== v.kind)
            begin
                $error("kind_out: expected %0d, actual %0d", v.kind, user[3:2]);
                failures++;
            end
            if (data[11:8] !== v.used)
            begin
                $error("entries_used: expected %0d, actual %0d", v.used, data[11:8]);
                failures++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n            = 1'b0;
    logic           s_axis_tvalid    = 1'b0;
    logic           s_axis_tready;
    logic [151:0]   s_axis_tdata     = '0;
    logic [4:0]     s_axis_tuser     = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready    = 1'b0;
    logic [15:0]    m_axis_tdata;
    logic [3:0]     m_axis_tuser;

    filter_checker  sb;
    bit             no_idle          = 1'b0;
    bit             hold_off_pending = 1'b0;
    int             requests_sent    = 0;

    mac_address_filter_match DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic filter_request_t make_request(req_t req, logic rx_error,
        logic [KIND_W-1:0] kind, logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
        logic [MAC_W-1:0] ap, logic [2:0] en);
        filter_request_t r;
        r.req      = req;
        r.rx_error = rx_error;
        r.kind     = kind;
        r.dst      = dst;
        r.src      = src;
        r.ap       = ap;
        r.en       = en;
        return r;
    endfunction

    // half random, half from a small pool so frames collide with filters
    function automatic logic [MAC_W-1:0] pick_mac();
        logic [MAC_W-1:0] m;
        m = MAC_W'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = '1;
            2: m = {24'h020000, 24'($urandom_range(0, 3))};
            default: ;
        endcase
        return m;
    endfunction

    function automatic filter_request_t random_request(req_t req);
        return make_request(req, 1'($urandom_range(0, 1)), KIND_W'($urandom_range(0, 3)),
                            pick_mac(), pick_mac(), pick_mac(), 3'($urandom_range(0, 7)));
    endfunction

    task automatic send_request(input filter_request_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r.en[EN_AP], r.en[EN_SRC], r.en[EN_DST], r.ap, r.src, r.dst};
        s_axis_tuser  <= {r.kind, r.rx_error, r.req};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(r);
        if (r.req != REQ_SPARE)
            requests_sent++;
    endtask

    // frames mostly copy a stored filter, sometimes with one address bit flipped
    task automatic send_frame();
        filter_request_t r;
        int idx;
        r = random_request(REQ_FRAME);
        r.rx_error = ($urandom_range(0, 7) == 0);
        if (sb.filter_count > 0 && $urandom_range(0, 3) != 0)
        begin
            idx   = $urandom_range(0, sb.filter_count - 1);
            r.dst = sb.dst_tab[idx];
            r.src = sb.src_tab[idx];
            r.ap  = sb.ap_tab[idx];
            case ($urandom_range(0, 5))
                0: r.dst ^= MAC_W'(1) << $urandom_range(0, MAC_W - 1);
                1: r.src ^= MAC_W'(1) << $urandom_range(0, MAC_W - 1);
                2: r.ap  ^= MAC_W'(1) << $urandom_range(0, MAC_W - 1);
                default: ;
            endcase
        end
        send_request(r);
    endtask

    // output side, one stall drawn per result transfer
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
                stall = LONG_HOLD;
            else
                stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        int seq_kind;
        int n;
        sb = new();
        wait (rst_n);
        @(posedge clk);

        // empty table, unused code, filters on each single address
        send_request(make_request(REQ_FRAME, 1'b0, 2'd3, '1, '1, '1, 3'd0));
        send_request(make_request(REQ_SPARE, 1'b1, 2'd3, '1, '1, '1, 3'b111));
        send_request(make_request(REQ_ADD, 1'b0, 2'd0, '0, '0, '0, 3'b000));
        send_request(make_request(REQ_ADD, 1'b1, 2'd3, '1, '0, '0, 3'b001));
        send_request(make_request(REQ_ADD, 1'b0, 2'd1, '0, '1, '0, 3'b010));
        send_request(make_request(REQ_ADD, 1'b0, 2'd2, '0, '0, '1, 3'b100));
        send_request(make_request(REQ_ADD, 1'b0, 2'd0, '1, '1, '1, 3'b111));
        send_request(make_request(REQ_FRAME, 1'b0, 2'd2, '1, '1, '1, 3'd0));
        send_request(make_request(REQ_FRAME, 1'b0, 2'd0, '0, '0, '0, 3'd0));
        repeat (3) send_request(random_request(REQ_ADD));
        // full table
        send_request(make_request(REQ_ADD, 1'b1, 2'd3, '1, '1, '1, 3'b111));
        send_request(make_request(REQ_FRAME, 1'b0, 2'd1, '1, '0, '0, 3'd0));
        send_request(make_request(REQ_FRAME, 1'b0, 2'd3, '1, '1, '1, 3'b111));
        send_request(make_request(REQ_FRAME, 1'b1, 2'd3, '1, '1, '1, 3'b111));
        send_request(make_request(REQ_SPARE, 1'b0, 2'd0, '0, '0, '0, 3'd0));
        send_request(make_request(REQ_CLEAR, 1'b1, 2'd3, '1, '1, '1, 3'b111));
        send_request(make_request(REQ_FRAME, 1'b0, 2'd1, '0, '0, '0, 3'd0));
        send_request(make_request(REQ_CLEAR, 1'b0, 2'd0, '0, '0, '0, 3'd0));
        send_request(make_request(REQ_ADD, 1'b0, 2'd0, '1, '1, '1, 3'b011));
        send_request(make_request(REQ_FRAME, 1'b0, 2'd2, '1, '1, '0, 3'd0));

        hold_off_pending = 1'b1;
        while (requests_sent < ITEM_TARGET)
        begin
            seq_kind = $urandom_range(0, 9);
            no_idle  = ($urandom_range(0, 4) == 0);
            if (seq_kind <= 6)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_request(random_request(REQ_CLEAR));
                n = $urandom_range(0, 10);
                repeat (n) send_request(random_request(REQ_ADD));
                n = $urandom_range(1, 12);
                repeat (n) send_frame();
            end
            else if (seq_kind == 7)
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_request(random_request(req_t'($urandom_range(0, 3))));
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_frame();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.verdicts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0)
            $display("mac_address_filter_match: match");
        else
            $display("mac_address_filter_match: mismatch");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("mac_address_filter_match: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
